FILE: sv/mbdlp_pkg.sv
// shared constants and types for the multi-button debounce block
package mbdlp_pkg;

   localparam int BUTTON_COUNT_DEF = 5;
   localparam int FIRST_PIN_DEF    = 1;
   localparam int TIME_WIDTH_DEF   = 32;

   localparam int PORT_WIDTH  = 8;
   localparam int STAMP_WIDTH = 32;
   localparam int INDEX_WIDTH = 3;
   localparam int MASK_WIDTH  = 5;
   localparam int CSR_WIDTH   = 32;
   localparam int ADDR_WIDTH  = 4;
   localparam int REG_SEL_WIDTH = 2;

   localparam logic [REG_SEL_WIDTH-1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [REG_SEL_WIDTH-1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [REG_SEL_WIDTH-1:0] REG_LONG_EN    = 2'd2;

   localparam logic [CSR_WIDTH-1:0] DEBOUNCE_RESET   = 32'd50;
   localparam logic [CSR_WIDTH-1:0] LONG_PRESS_RESET = 32'd1000;

   localparam logic KIND_PRESS = 1'b0;
   localparam logic KIND_LONG  = 1'b1;

   typedef struct packed {
      logic [CSR_WIDTH-1:0] debounce_ms;
      logic [CSR_WIDTH-1:0] long_press_ms;
      logic                 long_press_enable;
   } mbdlp_cfg_type;

   typedef struct packed {
      logic valid;
      logic kind;
   } mbdlp_event_type;

endpackage

FILE: sv/mbdlp_if.sv
// handshake channels for port samples and button events
interface mbdlp_req_if
   import mbdlp_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [PORT_WIDTH-1:0]  port_bits;
   logic [STAMP_WIDTH-1:0] now_ms;

   modport source (output valid, port_bits, now_ms, input ready);
   modport sink   (input valid, port_bits, now_ms, output ready);
endinterface

interface mbdlp_rsp_if
   import mbdlp_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] button_index;
   logic                   event_kind;
   logic                   last_event;
   logic [MASK_WIDTH-1:0]  pressed_mask;

   modport source (output valid, button_index, event_kind, last_event, pressed_mask,
                   input ready);
   modport sink   (input valid, button_index, event_kind, last_event, pressed_mask,
                   output ready);
endinterface

FILE: sv/mbdlp_csr.sv
// configuration registers behind the apb-style port
module mbdlp_csr
   import mbdlp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_WIDTH-1:0]  csr_prdata,
   output logic                  csr_pready,
   output mbdlp_cfg_type         cfg
);

   logic [CSR_WIDTH-1:0]     debounce_ff, debounce_in;
   logic [CSR_WIDTH-1:0]     long_ms_ff, long_ms_in;
   logic                     enable_ff, enable_in;
   logic                     wr_en;
   logic [REG_SEL_WIDTH-1:0] reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[ADDR_WIDTH-1:2];

   always_comb begin
      debounce_in = debounce_ff;
      long_ms_in  = long_ms_ff;
      enable_in   = enable_ff;
      csr_prdata  = '0;
      unique case (reg_sel)
         REG_DEBOUNCE: begin
            csr_prdata = debounce_ff;
            if (wr_en) debounce_in = csr_pwdata;
         end
         REG_LONG_PRESS: begin
            csr_prdata = long_ms_ff;
            if (wr_en) long_ms_in = csr_pwdata;
         end
         REG_LONG_EN: begin
            csr_prdata = CSR_WIDTH'(enable_ff);
            if (wr_en) enable_in = csr_pwdata[0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         long_ms_ff  <= LONG_PRESS_RESET;
         enable_ff   <= 1'b0;
      end else begin
         debounce_ff <= debounce_in;
         long_ms_ff  <= long_ms_in;
         enable_ff   <= enable_in;
      end
   end

   assign cfg.debounce_ms       = debounce_ff;
   assign cfg.long_press_ms     = long_ms_ff;
   assign cfg.long_press_enable = enable_ff;

endmodule

FILE: sv/mbdlp_lane.sv
// per-button lockout debounce and long-press timer
module mbdlp_lane
   import mbdlp_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  raw_pressed,
   input  logic [TIME_WIDTH-1:0] now,
   input  mbdlp_cfg_type         cfg,
   output mbdlp_event_type       evt,
   output logic                  pressed_next
);

   localparam int CMP_WIDTH = (TIME_WIDTH > CSR_WIDTH) ? TIME_WIDTH : CSR_WIDTH;

   logic [TIME_WIDTH-1:0] change_stamp_ff, change_stamp_in;
   logic [TIME_WIDTH-1:0] press_stamp_ff, press_stamp_in;
   logic                  pressed_ff, pressed_in;
   logic                  fired_ff, fired_in;

   logic [TIME_WIDTH-1:0] since_change, since_press;
   logic                  changed, change_ok, long_ok, take_change, take_long;

   // differences wrap modulo the stamp width
   assign since_change = now - change_stamp_ff;
   assign since_press  = now - press_stamp_ff;

   assign changed   = raw_pressed != pressed_ff;
   assign change_ok = CMP_WIDTH'(since_change) >= CMP_WIDTH'(cfg.debounce_ms);
   assign long_ok   = CMP_WIDTH'(since_press) >= CMP_WIDTH'(cfg.long_press_ms);

   assign take_change = changed && change_ok;
   assign take_long   = !changed && pressed_ff && cfg.long_press_enable && !fired_ff
                        && long_ok;

   assign evt.valid    = (take_change && raw_pressed) || take_long;
   assign evt.kind     = take_long ? KIND_LONG : KIND_PRESS;
   assign pressed_next = take_change ? raw_pressed : pressed_ff;

   always_comb begin
      change_stamp_in = change_stamp_ff;
      press_stamp_in  = press_stamp_ff;
      pressed_in      = pressed_ff;
      fired_in        = fired_ff;
      if (accept) begin
         if (take_change) begin
            change_stamp_in = now;
            pressed_in      = raw_pressed;
            if (raw_pressed) begin
               press_stamp_in = now;
               fired_in       = 1'b0;
            end
         end else if (take_long) begin
            fired_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         change_stamp_ff <= '0;
         press_stamp_ff  <= '0;
         pressed_ff      <= 1'b0;
         fired_ff        <= 1'b0;
      end else begin
         change_stamp_ff <= change_stamp_in;
         press_stamp_ff  <= press_stamp_in;
         pressed_ff      <= pressed_in;
         fired_ff        <= fired_in;
      end
   end

endmodule

FILE: sv/mbdlp_merge.sv
// gathers lane events and sends them out one word at a time in button order
module mbdlp_merge
   import mbdlp_pkg::*;
#(
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  mbdlp_event_type [BUTTON_COUNT-1:0]   evts,
   input  logic [BUTTON_COUNT-1:0]              pressed_next,
   output logic                                 take_ready,
   mbdlp_rsp_if.source                          rsp
);

   logic [BUTTON_COUNT-1:0] pend_ff, pend_in;
   logic [BUTTON_COUNT-1:0] kinds_ff, kinds_in;
   logic [MASK_WIDTH-1:0]   mask_ff, mask_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                   kind_ff, kind_in;
   logic                   last_ff, last_in;
   logic [MASK_WIDTH-1:0]  omask_ff, omask_in;

   logic [BUTTON_COUNT-1:0] ev_bits, ev_kinds, pick, rest;
   logic [INDEX_WIDTH-1:0]  pick_idx;
   logic [PORT_WIDTH-1:0]   mask_full;
   logic                    out_free, move;

   always_comb begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         ev_bits[i]  = evts[i].valid;
         ev_kinds[i] = evts[i].kind;
      end
   end

   // lowest pending button goes first
   always_comb begin
      pick     = '0;
      pick_idx = '0;
      for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pick     = BUTTON_COUNT'(1) << i;
            pick_idx = INDEX_WIDTH'(i);
         end
      end
   end

   assign rest       = pend_ff & ~pick;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign move       = out_free && (pend_ff != '0);
   assign take_ready = (pend_ff == '0) || (move && (rest == '0));
   assign mask_full  = PORT_WIDTH'(pressed_next);

   always_comb begin
      pend_in  = move ? rest : pend_ff;
      kinds_in = kinds_ff;
      mask_in  = mask_ff;
      if (accept) begin
         pend_in  = ev_bits;
         kinds_in = ev_kinds;
         mask_in  = mask_full[MASK_WIDTH-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      omask_in     = omask_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         idx_in       = pick_idx;
         kind_in      = |(kinds_ff & pick);
         last_in      = rest == '0;
         omask_in     = mask_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kinds_ff <= kinds_in;
      mask_ff  <= mask_in;
      idx_ff   <= idx_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
      omask_ff <= omask_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.button_index = idx_ff;
   assign rsp.event_kind   = kind_ff;
   assign rsp.last_event   = last_ff;
   assign rsp.pressed_mask = omask_ff;

   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pick))
      else $error("more than one button picked");

   a_move_shows: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("picked event not shown");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> (pend_ff == $past(ev_bits)))
      else $error("pending set not loaded from lanes");

   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |-> (pend_ff != '0))
      else $error("non-final word shown with nothing pending");

endmodule

FILE: sv/multi_button_debounce_long_press.sv
// top level: button lanes, event merge and configuration registers
//
// req_chan carries one port sample (port_bits, active low) with its
// millisecond stamp now_ms. Buttons sit on consecutive pins from FIRST_PIN;
// a pin above 7 reads as released. rsp_chan carries one word per event,
// press or long press, in button order, the last word of a sample flagged
// by last_event and every word carrying the debounced pressed_mask.
// A sample that causes no event produces no word.
// A sample's events are held in a pending set when the sample is accepted,
// and each word then moves from there to the output register. Words leave
// one per cycle while rsp_chan is ready, and a sample with no events does not
// hold up the next; the next sample is taken in the cycle the previous
// sample's last word moves to the output register.
// When rsp_chan stalls, pending words wait and req_chan.ready stays low
// until the last of them can move. Reset clears all stamps and flags, drops
// any pending word and loads debounce 50 ms, long press 1000 ms, disabled.
// Configuration writes go through the csr_ port and take effect at once.
module multi_button_debounce_long_press
   import mbdlp_pkg::*;
#(
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
   parameter int FIRST_PIN    = FIRST_PIN_DEF,
   parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   mbdlp_req_if.sink             req_chan,
   mbdlp_rsp_if.source           rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_WIDTH-1:0]  csr_prdata,
   output logic                  csr_pready
);

   mbdlp_cfg_type                      cfg;
   mbdlp_event_type [BUTTON_COUNT-1:0] evts;
   logic [BUTTON_COUNT-1:0]            pressed_next;
   logic [BUTTON_COUNT-1:0]            raw;
   logic [TIME_WIDTH-1:0]              now;
   logic                               take_ready, accept;

   assign now      = TIME_WIDTH'(req_chan.now_ms);
   assign accept   = req_chan.valid && take_ready;
   assign req_chan.ready = take_ready;

   mbdlp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
      if (FIRST_PIN + i < PORT_WIDTH) begin : g_pin
         assign raw[i] = !req_chan.port_bits[FIRST_PIN + i];
      end else begin : g_nopin
         assign raw[i] = 1'b0;
      end

      mbdlp_lane #(
         .TIME_WIDTH (TIME_WIDTH)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .accept       (accept),
         .raw_pressed  (raw[i]),
         .now          (now),
         .cfg          (cfg),
         .evt          (evts[i]),
         .pressed_next (pressed_next[i])
      );
   end

   mbdlp_merge #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .evts         (evts),
      .pressed_next (pressed_next),
      .take_ready   (take_ready),
      .rsp          (rsp_chan)
   );

endmodule
